/* design/pitm_pkg.sv */
// Shared constants for the point-in-triangle test pipeline.
package pitm_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LIMB_WIDTH      = 24;
  localparam int MUL_STAGES      = 5;

endpackage

/* design/pitm_mul.sv */
// Pipelined signed multiplier: sign-magnitude, limb partial products, two summing stages.
module pitm_mul #(
  parameter int OP_WIDTH = pitm_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                             clk,
  input  logic [pitm_pkg::MUL_STAGES-1:0]  en,
  input  logic signed [OP_WIDTH-1:0]       a,
  input  logic signed [OP_WIDTH-1:0]       b,
  output logic signed [2*OP_WIDTH-1:0]     p
);
  import pitm_pkg::*;

  localparam int NL  = (OP_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
  localparam int MW  = NL * LIMB_WIDTH;
  localparam int PPW = 2 * LIMB_WIDTH;
  localparam int RW  = LIMB_WIDTH * (NL + 1) + 1;
  localparam int TW  = 2 * MW;
  localparam int PW  = 2 * OP_WIDTH;

  logic [OP_WIDTH-1:0] abs_a, abs_b;
  logic [MW-1:0]       mag_a_r, mag_b_r;
  logic                neg_r [MUL_STAGES-1];
  logic [PPW-1:0]      pp_nxt [NL][NL];
  logic [PPW-1:0]      pp_r   [NL][NL];
  logic [RW-1:0]       row_nxt [NL];
  logic [RW-1:0]       row_r   [NL];
  logic [TW-1:0]       tot_nxt, tot_r;
  logic [PW-1:0]       mag_p;
  logic signed [PW-1:0] p_nxt, p_r;

  assign abs_a = a[OP_WIDTH-1] ? OP_WIDTH'(-a) : OP_WIDTH'(a);
  assign abs_b = b[OP_WIDTH-1] ? OP_WIDTH'(-b) : OP_WIDTH'(b);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp_nxt[i][j] = mag_a_r[i*LIMB_WIDTH +: LIMB_WIDTH] * mag_b_r[j*LIMB_WIDTH +: LIMB_WIDTH];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (LIMB_WIDTH * j));
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int i = 0; i < NL; i++) begin
      tot_nxt = tot_nxt + (TW'(row_r[i]) << (LIMB_WIDTH * i));
    end
  end

  assign mag_p = tot_r[PW-1:0];
  assign p_nxt = neg_r[MUL_STAGES-2] ? -mag_p : mag_p;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a_r  <= MW'(abs_a);
      mag_b_r  <= MW'(abs_b);
      neg_r[0] <= a[OP_WIDTH-1] ^ b[OP_WIDTH-1];
    end
    if (en[1]) begin
      pp_r     <= pp_nxt;
      neg_r[1] <= neg_r[0];
    end
    if (en[2]) begin
      row_r    <= row_nxt;
      neg_r[2] <= neg_r[1];
    end
    if (en[3]) begin
      tot_r    <= tot_nxt;
      neg_r[3] <= neg_r[2];
    end
    if (en[4]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* design/point_in_triangle_test.sv */
// Barycentric point-in-triangle test, fully pipelined, one query per cycle.
//
// Input channel: in_valid / in_stall with the three corners and the query point,
// each a signed Q16.16 coordinate of COORD_WIDTH bits. Result channel:
// out_valid / out_stall with out_inside_res and out_degenerate. A transaction
// completes on a clock edge with valid high and stall low.
// From input transaction to result transaction there is one stage for the edge
// vectors, two 5-stage multiplier pipelines (edge products, then products of dot
// products), one stage for the dot sums, and three stages for the determinant,
// the numerator sum and the final compare. Throughput is one transaction per
// cycle while out_stall is low, set by the fully pipelined multipliers.
// Every stage carries its own valid bit; a stalled receiver freezes only the full
// stages behind the output, so bubbles close up and in_stall rises only once the
// first stage is occupied and cannot move on.
// Synchronous active-low reset empties the pipeline; data registers are not reset.
// A zero Gram determinant gives out_degenerate = 1 and out_inside_res = 0.
module point_in_triangle_test #(
  parameter int COORD_WIDTH = pitm_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_z,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_inside_res,
  output logic                          out_degenerate
);
  import pitm_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PA   = 2 * DW;
  localparam int DTW  = PA + 2;
  localparam int PB   = 2 * DTW;
  localparam int NW   = PB + 1;
  localparam int SW   = NW + 1;

  localparam int S_DIFF = 1;
  localparam int S_DOT  = S_DIFF + MUL_STAGES + 1;
  localparam int S_MIX  = S_DOT + MUL_STAGES + 1;
  localparam int S_SUM  = S_MIX + 1;
  localparam int S_OUT  = S_SUM + 1;

  localparam int NDOT = 5;
  localparam int NPRD = 6;
  localparam int D11  = 0;
  localparam int D12  = 1;
  localparam int D13  = 2;
  localparam int D22  = 3;
  localparam int D23  = 4;

  // pipeline control
  logic [S_OUT:1]   v_r, v_nxt;
  logic [S_OUT+1:1] rdy;

  always_comb begin
    rdy[S_OUT+1] = !out_stall;
    for (int k = S_OUT; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt = (rdy[S_OUT:1] & {v_r[S_OUT-1:1], in_valid}) | (~rdy[S_OUT:1] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[S_DIFF];
  assign out_valid = v_r[S_OUT];

  // edge vectors
  logic signed [COORD_WIDTH-1:0] ca [3];
  logic signed [COORD_WIDTH-1:0] cb [3];
  logic signed [COORD_WIDTH-1:0] cc [3];
  logic signed [COORD_WIDTH-1:0] cq [3];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [DW-1:0] w_r  [3];

  always_comb begin
    ca[0] = in_corner_a_x;
    ca[1] = in_corner_a_y;
    ca[2] = in_corner_a_z;
    cb[0] = in_corner_b_x;
    cb[1] = in_corner_b_y;
    cb[2] = in_corner_b_z;
    cc[0] = in_corner_c_x;
    cc[1] = in_corner_c_y;
    cc[2] = in_corner_c_z;
    cq[0] = in_query_x;
    cq[1] = in_query_y;
    cq[2] = in_query_z;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_DIFF]) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= DW'(cb[k]) - DW'(ca[k]);
        e2_r[k] <= DW'(cc[k]) - DW'(ca[k]);
        w_r[k]  <= DW'(cq[k]) - DW'(ca[k]);
      end
    end
  end

  // edge products
  logic signed [DW-1:0] opa [NDOT][3];
  logic signed [DW-1:0] opb [NDOT][3];
  logic signed [PA-1:0] pa  [NDOT][3];
  logic [MUL_STAGES-1:0] en_a, en_b;

  assign en_a = rdy[S_DOT-1:S_DIFF+1];
  assign en_b = rdy[S_MIX-1:S_DOT+1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[D11][k] = e1_r[k];
      opb[D11][k] = e1_r[k];
      opa[D12][k] = e1_r[k];
      opb[D12][k] = e2_r[k];
      opa[D13][k] = e1_r[k];
      opb[D13][k] = w_r[k];
      opa[D22][k] = e2_r[k];
      opb[D22][k] = e2_r[k];
      opa[D23][k] = e2_r[k];
      opb[D23][k] = w_r[k];
    end
  end

  for (genvar d = 0; d < NDOT; d++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_axis
      pitm_mul #(.OP_WIDTH(DW)) u_mul (
        .clk (clk),
        .en  (en_a),
        .a   (opa[d][k]),
        .b   (opb[d][k]),
        .p   (pa[d][k])
      );
    end
  end

  // dot products
  logic signed [DTW-1:0] dot_r [NDOT];

  always_ff @(posedge clk) begin
    if (rdy[S_DOT]) begin
      for (int d = 0; d < NDOT; d++) begin
        dot_r[d] <= DTW'(pa[d][0]) + DTW'(pa[d][1]) + DTW'(pa[d][2]);
      end
    end
  end

  // products of dot products
  logic signed [DTW-1:0] opc [NPRD];
  logic signed [DTW-1:0] opd [NPRD];
  logic signed [PB-1:0]  pb  [NPRD];

  always_comb begin
    opc[0] = dot_r[D11];
    opd[0] = dot_r[D22];
    opc[1] = dot_r[D12];
    opd[1] = dot_r[D12];
    opc[2] = dot_r[D22];
    opd[2] = dot_r[D13];
    opc[3] = dot_r[D12];
    opd[3] = dot_r[D23];
    opc[4] = dot_r[D11];
    opd[4] = dot_r[D23];
    opc[5] = dot_r[D12];
    opd[5] = dot_r[D13];
  end

  for (genvar m = 0; m < NPRD; m++) begin : g_prd
    pitm_mul #(.OP_WIDTH(DTW)) u_mul (
      .clk (clk),
      .en  (en_b),
      .a   (opc[m]),
      .b   (opd[m]),
      .p   (pb[m])
    );
  end

  // determinant and numerators
  logic signed [NW-1:0] den_r, nu_r, nv_r;

  always_ff @(posedge clk) begin
    if (rdy[S_MIX]) begin
      den_r <= NW'(pb[0]) - NW'(pb[1]);
      nu_r  <= NW'(pb[2]) - NW'(pb[3]);
      nv_r  <= NW'(pb[4]) - NW'(pb[5]);
    end
  end

  logic signed [SW-1:0] sum_r, den_s_r;
  logic                 dz_r, nneg_r;

  always_ff @(posedge clk) begin
    if (rdy[S_SUM]) begin
      sum_r   <= SW'(nu_r) + SW'(nv_r);
      den_s_r <= SW'(den_r);
      dz_r    <= (den_r == '0);
      nneg_r  <= !nu_r[NW-1] && !nv_r[NW-1];
    end
  end

  logic inside_r, degen_r;

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      inside_r <= !dz_r && nneg_r && (sum_r <= den_s_r);
      degen_r  <= dz_r;
    end
  end

  assign out_inside_res = inside_r;
  assign out_degenerate = degen_r;

`ifndef SYNTHESIS
  a_degen_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_degenerate))
    else $error("degenerate result flagged inside");

  a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[S_DIFF])
    else $error("input stalled with empty first stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[S_OUT] && !out_stall && !v_r[S_OUT-1]) |=> !v_r[S_OUT])
    else $error("result repeated after transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* tb/point_in_triangle_test_tb.sv */
// Self-checking testbench for the point-in-triangle test pipeline.
module point_in_triangle_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = pitm_pkg::COORD_WIDTH_DEF;
  localparam int RANDOM_QUERIES = 1628;
  localparam int HOLD_AT = 600;
  localparam int DRAIN_AT = 1200;
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int ONE = 65536;
  localparam int QTR = 16384;
  localparam int MAXC = 32'h7fff_ffff;
  localparam int MINC = 32'h8000_0000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
    coord_t px, py, pz;
  } query_t;

  typedef struct packed {
    logic contained;
    logic degenerate;
  } verdict_t;

  class containment_scoreboard;
    verdict_t    expected_verdicts[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned n_contained;
    int unsigned n_outside;
    int unsigned n_degenerate;

    function wide_t widen(coord_t v);
      return {{(256 - CW){v[CW-1]}}, v};
    endfunction

    // exact integer form of u >= 0, v >= 0, u + v <= 1
    function verdict_t predict_containment(query_t q);
      wide_t    e1[3], e2[3], wq[3];
      wide_t    d11, d12, d13, d22, d23, den, nu, nv;
      verdict_t v;
      e1[0] = widen(q.bx) - widen(q.ax);
      e1[1] = widen(q.by) - widen(q.ay);
      e1[2] = widen(q.bz) - widen(q.az);
      e2[0] = widen(q.cx) - widen(q.ax);
      e2[1] = widen(q.cy) - widen(q.ay);
      e2[2] = widen(q.cz) - widen(q.az);
      wq[0] = widen(q.px) - widen(q.ax);
      wq[1] = widen(q.py) - widen(q.ay);
      wq[2] = widen(q.pz) - widen(q.az);
      d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d12 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
      d13 = e1[0] * wq[0] + e1[1] * wq[1] + e1[2] * wq[2];
      d22 = e2[0] * e2[0] + e2[1] * e2[1] + e2[2] * e2[2];
      d23 = e2[0] * wq[0] + e2[1] * wq[1] + e2[2] * wq[2];
      den = d11 * d22 - d12 * d12;
      nu  = d22 * d13 - d12 * d23;
      nv  = d11 * d23 - d12 * d13;
      v.degenerate = (den == 0);
      v.contained  = !v.degenerate && (nu >= 0) && (nv >= 0) && (nu + nv <= den);
      return v;
    endfunction

    function void note_query(query_t q);
      verdict_t v;
      v = predict_containment(q);
      if (v.degenerate) n_degenerate++;
      else if (v.contained) n_contained++;
      else n_outside++;
      expected_verdicts.push_back(v);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 25) $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
      mismatches++;
    endtask

    task check_outcome(logic contained, logic degenerate);
      verdict_t want;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction inside=%0b degenerate=%0b",
                                  contained, degenerate));
      end else begin
        want = expected_verdicts.pop_front();
        if (degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %0b, want %0b", degenerate, want.degenerate));
        if (contained !== want.contained)
          report_mismatch($sformatf("inside %0b, want %0b", contained, want.contained));
      end
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_corner_a_x = '0;
  coord_t in_corner_a_y = '0;
  coord_t in_corner_a_z = '0;
  coord_t in_corner_b_x = '0;
  coord_t in_corner_b_y = '0;
  coord_t in_corner_b_z = '0;
  coord_t in_corner_c_x = '0;
  coord_t in_corner_c_y = '0;
  coord_t in_corner_c_z = '0;
  coord_t in_query_x = '0;
  coord_t in_query_y = '0;
  coord_t in_query_z = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_inside_res;
  logic   out_degenerate;

  containment_scoreboard sb;
  bit long_hold = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned backpressure_cycles = 0;

  point_in_triangle_test dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_corner_a_x  (in_corner_a_x),
    .in_corner_a_y  (in_corner_a_y),
    .in_corner_a_z  (in_corner_a_z),
    .in_corner_b_x  (in_corner_b_x),
    .in_corner_b_y  (in_corner_b_y),
    .in_corner_b_z  (in_corner_b_z),
    .in_corner_c_x  (in_corner_c_x),
    .in_corner_c_y  (in_corner_c_y),
    .in_corner_c_z  (in_corner_c_z),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .in_query_z     (in_query_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res),
    .out_degenerate (out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int sym(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic query_t build_query(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, int px, int py, int pz);
    query_t q;
    q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz;
    q.cx = cx; q.cy = cy; q.cz = cz;
    q.px = px; q.py = py; q.pz = pz;
    return q;
  endfunction

  // point built from barycentric weights in eighths, so edges are hit exactly
  function automatic query_t make_planar_query();
    int     r, ax, ay, az, bx, by, bz, cx, cy, cz, wb, wc;
    query_t q;
    r  = 1 << (3 * $urandom_range(1, 7));
    ax = sym(r) * 8; ay = sym(r) * 8; az = sym(r) * 8;
    bx = sym(r) * 8; by = sym(r) * 8; bz = sym(r) * 8;
    cx = sym(r) * 8; cy = sym(r) * 8; cz = sym(r) * 8;
    wb = $urandom_range(0, 16) - 4;
    wc = $urandom_range(0, 16) - 4;
    q = build_query(ax, ay, az, bx, by, bz, cx, cy, cz,
                    ax + (wb * (bx - ax) + wc * (cx - ax)) / 8,
                    ay + (wb * (by - ay) + wc * (cy - ay)) / 8,
                    az + (wb * (bz - az) + wc * (cz - az)) / 8);
    if ($urandom_range(0, 3) == 0) q.pz = q.pz + sym(r);
    if ($urandom_range(0, 3) == 0) q.px = q.px + sym(2);
    return q;
  endfunction

  // corners on one line through A: B = A + m*d, C = A + k*d
  function automatic query_t make_degenerate_query();
    int ax, ay, az, dx, dy, dz, m, k;
    ax = sym(1 << 20); ay = sym(1 << 20); az = sym(1 << 20);
    dx = sym(1 << 10); dy = sym(1 << 10); dz = sym(1 << 10);
    m  = $urandom_range(0, 6) - 3;
    k  = $urandom_range(0, 6) - 3;
    return build_query(ax, ay, az, ax + m * dx, ay + m * dy, az + m * dz,
                       ax + k * dx, ay + k * dy, az + k * dz,
                       sym(1 << 22), sym(1 << 22), sym(1 << 22));
  endfunction

  function automatic query_t make_random_query();
    query_t q;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return make_planar_query();
    if (sel < 60) return make_degenerate_query();
    for (int i = 0; i < 12; i++) begin
      if (sel < 85) begin
        q[i*CW +: CW] = $urandom;
      end else begin
        case ($urandom_range(0, 5))
          0: q[i*CW +: CW] = MAXC;
          1: q[i*CW +: CW] = MINC;
          2: q[i*CW +: CW] = 0;
          3: q[i*CW +: CW] = -1;
          4: q[i*CW +: CW] = 1;
          default: q[i*CW +: CW] = $urandom;
        endcase
      end
    end
    return q;
  endfunction

  task automatic send_query(query_t q);
    in_corner_a_x <= q.ax;
    in_corner_a_y <= q.ay;
    in_corner_a_z <= q.az;
    in_corner_b_x <= q.bx;
    in_corner_b_y <= q.by;
    in_corner_b_z <= q.bz;
    in_corner_c_x <= q.cx;
    in_corner_c_y <= q.cy;
    in_corner_c_z <= q.cz;
    in_query_x    <= q.px;
    in_query_y    <= q.py;
    in_query_z    <= q.pz;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_query(q);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    // unit right triangle in the xy plane
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, QTR, QTR, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 2, ONE / 2, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 2, 0, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -QTR, QTR, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, QTR, -1, 0));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 40000, 40000, 0));
    // off the plane, judged by projection
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, QTR, QTR, 3 * ONE));
    send_query(build_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, 2 * ONE, -7 * ONE));
    // degenerate: coincident, collinear, repeated corner, all zero
    send_query(build_query(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE,
                           ONE, 2 * ONE, 3 * ONE, 0, 0, 0));
    send_query(build_query(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, QTR, QTR, QTR));
    send_query(build_query(5, 6, 7, 5, 6, 7, 9, -9, 3, 0, 0, 0));
    send_query(build_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // coordinate extremes
    send_query(build_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                           MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_query(build_query(MINC, MINC, MINC, MINC, MINC, MINC,
                           MINC, MINC, MINC, MINC, MINC, MINC));
    send_query(build_query(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, 0, 0));
    send_query(build_query(MAXC, MAXC, MAXC, MINC, MAXC, MAXC,
                           MAXC, MINC, MAXC, MINC, MINC, MINC));
    send_query(build_query(MINC, MAXC, MINC, MAXC, MINC, MAXC,
                           MINC, MINC, MAXC, MAXC, MAXC, MINC));
    send_query(build_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    // negative quadrant, point on the hypotenuse
    send_query(build_query(-3 * ONE, -3 * ONE, -3 * ONE, -ONE, -3 * ONE, -3 * ONE,
                           -3 * ONE, -ONE, -3 * ONE, -2 * ONE, -2 * ONE, -3 * ONE));
    // tilted triangle, near its centroid
    send_query(build_query(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 21845, 21845, 21846));
  endtask

  initial begin : stimulus
    int burst_left;
    sb = new();
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == HOLD_AT) begin
        // receiver holds off while the sender keeps offering
        long_hold  = 1'b1;
        burst_left = 48;
      end else if (n == DRAIN_AT) begin
        pause_sender(1);
        while (sb.pending() != 0) @(posedge clk);
        burst_left = 0;
      end
      if (burst_left == 0) begin
        pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
      send_query(make_random_query());
      burst_left--;
    end
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d inside, %0d outside, %0d degenerate.",
             sb.results_seen, sb.n_contained, sb.n_outside, sb.n_degenerate);
    $display("Input back-pressure seen on %0d cycles; one long output hold and a full drain.",
             backpressure_cycles);
    if (sb.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        if (long_hold) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          long_hold = 1'b0;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_outcome(out_inside_res, out_degenerate);
      if (in_valid && in_stall) backpressure_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
design/pitm_pkg.sv
design/pitm_mul.sv
design/point_in_triangle_test.sv
tb/point_in_triangle_test_tb.sv
